@@ rtl/assert_macros.svh @@
// Assertion macros shared by the board health fault monitor RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, off while reset is asserted.
`define BHFM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define BHFM_ASSERT_IMPL(label, ante, cons, msg) \
  `BHFM_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define BHFM_ASSERT_NEXT(label, ante, cons, msg) \
  `BHFM_ASSERT(label, (ante) |=> (cons), msg)

`endif

@@ rtl/bhfm_pkg.sv @@
// Shared types and constants for the board health fault monitor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bhfm_pkg;

  // Field widths fixed by the interface
  localparam int TEMP_W    = 18;
  localparam int VOLT_W    = 15;
  localparam int TO_W      = 16;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 3;

  // NTC table entries are wider than the board field to cover wide ADCs
  localparam int NTC_W = 22;
  localparam int SUM_W = NTC_W + 1;

  localparam logic signed [SUM_W-1:0] BOARD_MIN = -23'sd27315;
  localparam logic signed [SUM_W-1:0] BOARD_MAX = 23'sd100000;
  localparam int VOLT_MAX = 32000;
  localparam int TEMP_MAX = 100000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OVER_TEMP_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNDER_VOLT_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVER_VOLT_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNDER_TIMEOUT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OVER_TIMEOUT = 3'd5;

  // Register reset values
  localparam logic signed [TEMP_W-1:0] RST_OVER_TEMP_LIMIT = 18'sd5000;
  localparam logic [VOLT_W-1:0] RST_UNDER_VOLT_LIMIT = 15'd18000;
  localparam logic [VOLT_W-1:0] RST_OVER_VOLT_LIMIT = 15'd25000;
  localparam logic [TO_W-1:0] RST_TIMEOUT = 16'd1000;

  // Queue between the conversion front and the check back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

@@ rtl/bhfm_queue.sv @@
// Small FIFO that decouples conversion from limit checking.
// Depends on bhfm_pkg for depth and status type.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bhfm_queue
  import bhfm_pkg::*;
#(
  parameter int DATA_W = 65
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] push_data_i,
  input  wire logic              pop_i,
  output logic      [DATA_W-1:0] pop_data_o,
  output q_status_t              status_o
);

  logic [DATA_W-1:0]  mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] count_q, count_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + Q_CNT_W'(push_i) - Q_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign pop_data_o     = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == Q_CNT_W'(Q_DEPTH));
  assign status_o.empty = (count_q == '0);

  `BHFM_ASSERT(a_no_overflow, !(push_i && status_o.full), "push into full queue")
  `BHFM_ASSERT(a_no_underflow, !(pop_i && status_o.empty), "pop from empty queue")

endmodule

`default_nettype wire

@@ rtl/bhfm_front.sv @@
// Front end: accepts ADC sample sets, converts them through build-time tables
// and forms the board temperature. Depends on bhfm_pkg; feeds bhfm_queue.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bhfm_front
  import bhfm_pkg::*;
#(
  parameter int ADC_BITS  = 12,
  parameter int TICK_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [ADC_BITS-1:0]  chip_temp_code_i,
  input  wire logic [ADC_BITS-1:0]  ntc_temp_code_i,
  input  wire logic [ADC_BITS-1:0]  supply_code_i,
  input  wire logic [TICK_BITS-1:0] now_ticks_i,
  input  wire q_status_t            q_status_i,
  output logic                      push_o,
  output logic [TEMP_W+VOLT_W+TICK_BITS-1:0] push_data_o
);

  localparam int          Depth = 1 << ADC_BITS;
  localparam logic [63:0] Full  = (64'd1 << ADC_BITS) - 64'd1;

  // Restoring long division, used only while the tables are built
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // log2 in Q28 by repeated squaring of a Q30 mantissa, truncated
  function automatic logic [63:0] log2_q28(input logic [63:0] x);
    logic [63:0] m;
    logic [63:0] frac;
    int          k;
    k = 0;
    while ((x >> (k + 1)) != 64'd0) begin
      k++;
    end
    m    = x << (30 - k);
    frac = '0;
    for (int i = 27; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m       = m >> 1;
        frac[i] = 1'b1;
      end
    end
    return (64'(k) << 28) | frac;
  endfunction

  function automatic longint chip_centi(input logic [63:0] c);
    logic [63:0] q;
    q = udiv64(64'd264000 * c + Full, Full << 1);
    return longint'(q) - 64'sd27900;
  endfunction

  function automatic logic [63:0] supply_milli(input logic [63:0] c);
    logic [63:0] den;
    logic [63:0] mv;
    den = 64'd106464 * Full;
    mv  = udiv64(c * 64'd3300000000 + (den >> 1), den) + 64'd600;
    if (mv > 64'(VOLT_MAX)) begin
      mv = 64'(VOLT_MAX);
    end
    return mv;
  endfunction

  function automatic longint ntc_centi(input logic [63:0] code);
    logic [63:0] c;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] mag;
    logic [63:0] den_u;
    longint      lq;
    longint      den;
    c = code;
    if (c < 64'd1) begin
      c = 64'd1;
    end
    if (c > Full - 64'd1) begin
      c = Full - 64'd1;
    end
    a   = log2_q28(c);
    b   = log2_q28(Full - c);
    mag = (((a >= b) ? (a - b) : (b - a)) * 64'd744261118) >> 30;
    lq  = (a >= b) ? longint'(mag) : -longint'(mag);
    den = longint'(64'd338000 << 28) + 64'sd29815 * lq;
    if (den <= 64'sd0) begin
      return longint'(TEMP_MAX);
    end
    den_u = 64'(den);
    return longint'(udiv64((64'd10077470000 << 28) + (den_u >> 1), den_u)) - 64'sd27315;
  endfunction

  logic signed [TEMP_W-1:0] chip_rom [Depth];
  logic signed [NTC_W-1:0]  ntc_rom  [Depth];
  logic        [VOLT_W-1:0] volt_rom [Depth];

  for (genvar g = 0; g < Depth; g++) begin : g_rom
    localparam logic signed [TEMP_W-1:0] ChipVal = TEMP_W'(chip_centi(64'(g)));
    localparam logic signed [NTC_W-1:0]  NtcVal  = NTC_W'(ntc_centi(64'(g)));
    localparam logic        [VOLT_W-1:0] VoltVal = VOLT_W'(supply_milli(64'(g)));
    assign chip_rom[g] = ChipVal;
    assign ntc_rom[g]  = NtcVal;
    assign volt_rom[g] = VoltVal;
  end

  logic                     valid_q;
  logic                     accept;
  logic signed [TEMP_W-1:0] chip_q;
  logic signed [NTC_W-1:0]  ntc_q;
  logic        [VOLT_W-1:0] mv_q;
  logic [TICK_BITS-1:0]     now_q;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  half;
  logic signed [TEMP_W-1:0] board;

  // Hold the converted item while the queue is full
  assign in_stall_o = valid_q && q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      chip_q <= chip_rom[chip_temp_code_i];
      ntc_q  <= ntc_rom[ntc_temp_code_i];
      mv_q   <= volt_rom[supply_code_i];
      now_q  <= now_ticks_i;
    end
  end

  // Mean rounded half up, then clamp to the reportable range
  always_comb begin
    sum  = SUM_W'(chip_q) + SUM_W'(ntc_q) + SUM_W'(1);
    half = sum >>> 1;
    priority if (half < BOARD_MIN) begin
      board = TEMP_W'(BOARD_MIN);
    end else if (half > BOARD_MAX) begin
      board = TEMP_W'(BOARD_MAX);
    end else begin
      board = TEMP_W'(half);
    end
  end

  assign push_o      = valid_q && !q_status_i.full;
  assign push_data_o = {board, mv_q, now_q};

  `BHFM_ASSERT_NEXT(a_hold_on_stall, in_stall_o, valid_q, "stalled item lost")

endmodule

`default_nettype wire

@@ rtl/bhfm_back.sv @@
// Back end: holds the limit registers and ok-stamps, raises the fault flags
// and drives the output register. Depends on bhfm_pkg; drains bhfm_queue.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bhfm_back
  import bhfm_pkg::*;
#(
  parameter int TICK_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire q_status_t            q_status_i,
  input  wire logic [TEMP_W+VOLT_W+TICK_BITS-1:0] pop_data_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [TEMP_W-1:0]  board_temp_centi_o,
  output logic [VOLT_W-1:0]         supply_mv_o,
  output logic                      over_temp_fault_o,
  output logic                      under_volt_fault_o,
  output logic                      over_volt_fault_o
);

  logic signed [TEMP_W-1:0] ot_limit_q;
  logic [VOLT_W-1:0]        uv_limit_q;
  logic [VOLT_W-1:0]        ov_limit_q;
  logic [TO_W-1:0]          ot_timeout_q;
  logic [TO_W-1:0]          uv_timeout_q;
  logic [TO_W-1:0]          ov_timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ot_limit_q   <= RST_OVER_TEMP_LIMIT;
      uv_limit_q   <= RST_UNDER_VOLT_LIMIT;
      ov_limit_q   <= RST_OVER_VOLT_LIMIT;
      ot_timeout_q <= RST_TIMEOUT;
      uv_timeout_q <= RST_TIMEOUT;
      ov_timeout_q <= RST_TIMEOUT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OVER_TEMP_LIMIT:  ot_limit_q   <= cfg_data_i[TEMP_W-1:0];
        CFG_UNDER_VOLT_LIMIT: uv_limit_q   <= cfg_data_i[VOLT_W-1:0];
        CFG_OVER_VOLT_LIMIT:  ov_limit_q   <= cfg_data_i[VOLT_W-1:0];
        CFG_TEMP_TIMEOUT:     ot_timeout_q <= cfg_data_i[TO_W-1:0];
        CFG_UNDER_TIMEOUT:    uv_timeout_q <= cfg_data_i[TO_W-1:0];
        CFG_OVER_TIMEOUT:     ov_timeout_q <= cfg_data_i[TO_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [TEMP_W-1:0] board;
  logic [VOLT_W-1:0]        mv;
  logic [TICK_BITS-1:0]     now;

  assign {board, mv, now} = pop_data_i;

  logic                 started_q;
  logic [TICK_BITS-1:0] ot_stamp_q, ot_stamp_d;
  logic [TICK_BITS-1:0] uv_stamp_q, uv_stamp_d;
  logic [TICK_BITS-1:0] ov_stamp_q, ov_stamp_d;
  logic                 ot_ok, uv_ok, ov_ok;
  logic                 ot_fault, uv_fault, ov_fault;

  logic                     out_valid_q;
  logic signed [TEMP_W-1:0] board_q;
  logic [VOLT_W-1:0]        mv_q;
  logic                     ot_fault_q, uv_fault_q, ov_fault_q;

  // Advance whenever the queue holds an item and the output register is free or being drained
  assign pop_o = !q_status_i.empty && (!out_valid_q || !out_stall_i);

  // A passing check reloads its stamp, so elapsed time is zero and no fault;
  // the first item loads every stamp.
  always_comb begin
    ot_ok = board < ot_limit_q;
    uv_ok = mv > uv_limit_q;
    ov_ok = mv < ov_limit_q;

    ot_stamp_d = (!started_q || ot_ok) ? now : ot_stamp_q;
    uv_stamp_d = (!started_q || uv_ok) ? now : uv_stamp_q;
    ov_stamp_d = (!started_q || ov_ok) ? now : ov_stamp_q;

    ot_fault = started_q && !ot_ok && ((now - ot_stamp_q) > TICK_BITS'(ot_timeout_q));
    uv_fault = started_q && !uv_ok && ((now - uv_stamp_q) > TICK_BITS'(uv_timeout_q));
    ov_fault = started_q && !ov_ok && ((now - ov_stamp_q) > TICK_BITS'(ov_timeout_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        started_q <= 1'b1;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ot_stamp_q <= ot_stamp_d;
      uv_stamp_q <= uv_stamp_d;
      ov_stamp_q <= ov_stamp_d;
      board_q    <= board;
      mv_q       <= mv;
      ot_fault_q <= ot_fault;
      uv_fault_q <= uv_fault;
      ov_fault_q <= ov_fault;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign board_temp_centi_o = board_q;
  assign supply_mv_o        = mv_q;
  assign over_temp_fault_o  = ot_fault_q;
  assign under_volt_fault_o = uv_fault_q;
  assign over_volt_fault_o  = ov_fault_q;

  `BHFM_ASSERT_NEXT(a_pop_fills_out, pop_o, out_valid_q, "popped item not presented")
  `BHFM_ASSERT_IMPL(a_fault_needs_start, out_valid_q && (ot_fault_q || uv_fault_q || ov_fault_q), started_q, "fault before first item")

endmodule

`default_nettype wire

@@ rtl/board_health_fault_monitor_core.sv @@
// Channel  Handshake                Payload
// in       in_valid_i / in_stall_o  chip/ntc/supply ADC codes, now_ticks_i
// out      out_valid_o / out_stall_i board temperature, supply mV, 3 fault flags
// cfg      cfg_we_i                 cfg_idx_i selects the register, cfg_data_i
//
// One item per cycle sustained while out_stall_i is low; an input transfer
// reaches the result via table read, queue write and output register. The
// conversion tables are read together; the stamp checks run in the back end.
// Reset clears control state only; no clearing pass is needed.
// A 4-entry queue plus the output register absorb output stalls before the
// input side stalls.
// Top level; depends on bhfm_pkg, bhfm_front, bhfm_queue and bhfm_back.
`timescale 1ns / 1ps
`default_nettype none

module board_health_fault_monitor_core
  import bhfm_pkg::*;
#(
  parameter int ADC_BITS  = 12,
  parameter int TICK_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [ADC_BITS-1:0]  chip_temp_code_i,
  input  wire logic [ADC_BITS-1:0]  ntc_temp_code_i,
  input  wire logic [ADC_BITS-1:0]  supply_code_i,
  input  wire logic [TICK_BITS-1:0] now_ticks_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [TEMP_W-1:0]  board_temp_centi_o,
  output logic [VOLT_W-1:0]         supply_mv_o,
  output logic                      over_temp_fault_o,
  output logic                      under_volt_fault_o,
  output logic                      over_volt_fault_o
);

  localparam int DataW = TEMP_W + VOLT_W + TICK_BITS;

  q_status_t        q_status;
  logic             push;
  logic             pop;
  logic [DataW-1:0] push_data;
  logic [DataW-1:0] pop_data;

  bhfm_front #(
    .ADC_BITS (ADC_BITS),
    .TICK_BITS(TICK_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .chip_temp_code_i(chip_temp_code_i),
    .ntc_temp_code_i (ntc_temp_code_i),
    .supply_code_i   (supply_code_i),
    .now_ticks_i     (now_ticks_i),
    .q_status_i      (q_status),
    .push_o          (push),
    .push_data_o     (push_data)
  );

  bhfm_queue #(
    .DATA_W(DataW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .status_o   (q_status)
  );

  bhfm_back #(
    .TICK_BITS(TICK_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .q_status_i        (q_status),
    .pop_data_i        (pop_data),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .board_temp_centi_o(board_temp_centi_o),
    .supply_mv_o       (supply_mv_o),
    .over_temp_fault_o (over_temp_fault_o),
    .under_volt_fault_o(under_volt_fault_o),
    .over_volt_fault_o (over_volt_fault_o)
  );

endmodule

`default_nettype wire
